/* rtl/core/lmpl_pkg.sv */
// shared types, codes and constants of the led matrix power limiter
package lmpl_pkg;

    // input commands
    localparam logic [1:0] FN_SET   = 2'd0;
    localparam logic [1:0] FN_FILL  = 2'd1;
    localparam logic [1:0] FN_SHOW  = 2'd2;
    localparam logic [1:0] FN_CLEAR = 2'd3;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERPENTINE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION   = 4'd3;

    localparam logic [6:0]  BRIGHT_MAX   = 7'd100;
    localparam logic [6:0]  BRIGHT_RESET = 7'd50;
    localparam logic [15:0] BUDGET_RESET = 16'd2600;

    localparam int MA_PER_CHANNEL = 20;
    localparam int CHAN_MAX       = 255;
    // floor(v / 100) == (v * RECIP_100) >> RECIP_SHIFT for v below 43690
    localparam int RECIP_100      = 5243;
    localparam int RECIP_SHIFT    = 19;

    // p * 20 / (255 * 255) is p * 4 / 13005; with a ceiling reciprocal over 2^42,
    // floor(p * 4 / 13005) == (p * EST_RECIP) >> EST_SHIFT for p below 2^26
    localparam int               EST_RECIP_W = 29;
    localparam logic [28:0]      EST_RECIP   = 29'(((64'd1 << 42) + 64'd13004) / 64'd13005);
    localparam int               EST_SHIFT   = 40;

    // scale divider
    localparam int DIVD_W  = 32;
    localparam int DIVS_W  = 16;
    localparam int QUO_W   = 16;
    localparam int QSTEP_W = $clog2(QUO_W);

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    // brightness percent to a 0..255 scale, b * 255 / 100
    function automatic logic [7:0] bright_scale(input logic [6:0] pct);
        logic [14:0] p;
        logic [27:0] q;
        p = (15'(pct) << 8) - 15'(pct);
        q = 28'(p) * 28'(RECIP_100);
        return q[RECIP_SHIFT+7:RECIP_SHIFT];
    endfunction

    // c * s / 255, exact for products below 65535
    function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [7:0] s);
        logic [15:0] p;
        logic [16:0] t;
        p = 16'(c) * 16'(s);
        t = 17'(p) + 17'(p >> 8) + 17'd1;
        return t[15:8];
    endfunction

endpackage

/* rtl/core/lmpl_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
module lmpl_div (
    input  logic               clk,
    input  logic               rst_n,
    input  lmpl_pkg::div_req_t req,
    output lmpl_pkg::div_rsp_t rsp
);
    import lmpl_pkg::*;

    logic                      busy_reg;
    logic                      done_reg;
    logic [QSTEP_W-1:0]        step_reg;
    logic [DIVD_W-1:0]         rem_reg;
    logic [DIVS_W+QUO_W-2:0]   dsh_reg;
    logic [QUO_W-1:0]          quo_reg;
    logic                      ge;
    logic [DIVD_W-1:0]         rem_sub;

    always_comb
    begin
        ge      = rem_reg >= DIVD_W'(dsh_reg);
        rem_sub = rem_reg - DIVD_W'(dsh_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= QSTEP_W'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend;
            dsh_reg <= {req.divisor, {(QUO_W-1){1'b0}}};
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_sub;
            end
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* rtl/core/led_matrix_power_limiter.sv */
// top level: frame store, pixel mapping, current estimate and scaled show output
//
// A set pixel or fill item leaves the block in the idle state, so it is ready for
// the next item at once. A show or clear item reads the whole frame once to sum
// it, forms the current estimate (product, reciprocal multiply, budget compare)
// and, when over budget, runs the divider on the reduced scale; then it fetches
// the first entry, the frame is read a second time and one pixel leaves per cycle
// while the output side takes them. The single read port of the frame memory sets
// both passes. Fill and reset do not sweep the memory: a valid bit per entry
// selects between the stored colour and the last fill colour (black after reset),
// so there is no clearing pass after reset. The next item is taken as soon as the
// final pixel sits in the output register.
module led_matrix_power_limiter #(
    parameter int SIDE = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         func,
    input  logic [3:0]                         x,
    input  logic [3:0]                         y,
    input  logic [7:0]                         red,
    input  logic [7:0]                         green,
    input  logic [7:0]                         blue,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [5:0]                         led_index,
    output logic [7:0]                         out_red,
    output logic [7:0]                         out_green,
    output logic [7:0]                         out_blue,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lmpl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lmpl_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lmpl_pkg::*;

    localparam int PIXELS = SIDE * SIDE;
    localparam int AW     = $clog2(PIXELS);
    localparam int CW     = $clog2(SIDE);
    localparam int SW     = $clog2(PIXELS * 3 * CHAN_MAX + 1);
    localparam int PW     = SW + 8;
    localparam int EW     = PW + EST_RECIP_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SUM      = 4'd1;
    localparam logic [3:0] S_SUM_END  = 4'd2;
    localparam logic [3:0] S_MUL      = 4'd3;
    localparam logic [3:0] S_EST      = 4'd4;
    localparam logic [3:0] S_CMP      = 4'd5;
    localparam logic [3:0] S_LIM_GO   = 4'd6;
    localparam logic [3:0] S_LIM_WAIT = 4'd7;
    localparam logic [3:0] S_EMIT_RD  = 4'd8;
    localparam logic [3:0] S_EMIT_LD  = 4'd9;

    // configuration
    logic [6:0]  bright_reg;
    logic [15:0] budget_reg;
    logic        serp_reg;
    logic [1:0]  rot_reg;

    // control
    logic [3:0]    state_reg;
    logic [AW-1:0] cnt_reg;
    logic          pend_reg;
    logic          out_valid_reg;

    // datapath
    logic [SW-1:0]    sum_reg;
    logic [7:0]       scale_reg;
    logic [PW-1:0]    prod_reg;
    logic [EW-1:0]    est_prod;
    logic [QUO_W-1:0] est_reg;
    rgb_t             fill_reg;
    logic [5:0]       led_index_reg;
    logic [7:0]       out_red_reg;
    logic [7:0]       out_green_reg;
    logic [7:0]       out_blue_reg;
    logic             last_reg;

    // frame memory and valid bits
    rgb_t          mem [PIXELS];
    logic [PIXELS-1:0] vld_reg;
    rgb_t          rd_data_reg;
    logic          vld_rd_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    rgb_t          pix;

    logic          in_acc;
    logic          coord_ok;
    logic [CW-1:0] xc;
    logic [CW-1:0] yc;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic          load;
    logic          at_last;

    div_req_t div_req;
    div_rsp_t div_rsp;

    lmpl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // logical to physical mapping
    always_comb
    begin
        coord_ok = ({1'b0, x} < 5'(SIDE)) && ({1'b0, y} < 5'(SIDE));
        xc = x[CW-1:0];
        yc = y[CW-1:0];
        case (rot_reg)
            2'd1:
            begin
                px = CW'(SIDE - 1) - yc;
                py = xc;
            end
            2'd2:
            begin
                px = CW'(SIDE - 1) - xc;
                py = CW'(SIDE - 1) - yc;
            end
            2'd3:
            begin
                px = yc;
                py = CW'(SIDE - 1) - xc;
            end
            default:
            begin
                px = xc;
                py = yc;
            end
        endcase
        if (serp_reg && py[0])
        begin
            px = CW'(SIDE - 1) - px;
        end
        wr_addr = AW'(AW'(py) * AW'(SIDE)) + AW'(px);
        wr_en   = in_acc && (func == FN_SET) && coord_ok;
    end

    assign at_last = (cnt_reg == AW'(PIXELS - 1));
    assign load    = (state_reg == S_EMIT_LD) && (!out_valid_reg || out_ready);
    assign pix     = vld_rd_reg ? rd_data_reg : fill_reg;

    // current estimate by reciprocal multiplication
    assign est_prod = EW'(prod_reg) * EW'(EST_RECIP);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = cnt_reg;
        if (state_reg == S_SUM || state_reg == S_EMIT_RD)
        begin
            rd_en = 1'b1;
        end
        else if (load && !at_last)
        begin
            rd_en   = 1'b1;
            rd_addr = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        div_req.start    = (state_reg == S_LIM_GO);
        div_req.dividend = DIVD_W'(24'(scale_reg) * 24'(budget_reg));
        div_req.divisor  = est_reg;
    end

    // frame memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= '{r: red, g: green, b: blue};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            vld_rd_reg  <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            fill_reg <= '0;
        end
        else if (in_acc && (func == FN_FILL))
        begin
            vld_reg  <= '0;
            fill_reg <= '{r: red, g: green, b: blue};
        end
        else if (in_acc && (func == FN_CLEAR))
        begin
            vld_reg  <= '0;
            fill_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg <= BRIGHT_RESET;
            budget_reg <= BUDGET_RESET;
            serp_reg   <= 1'b0;
            rot_reg    <= 2'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BRIGHTNESS:
                    bright_reg <= (cfg_data[6:0] > BRIGHT_MAX) ? BRIGHT_MAX : cfg_data[6:0];
                CFG_BUDGET:
                    budget_reg <= cfg_data;
                CFG_SERPENTINE:
                    serp_reg <= cfg_data[0];
                CFG_ROTATION:
                    rot_reg <= cfg_data[1:0];
                default:
                    ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= (state_reg == S_SUM);
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_acc && (func == FN_SHOW || func == FN_CLEAR))
                    begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    if (at_last)
                    begin
                        state_reg <= S_SUM_END;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_SUM_END:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                    state_reg <= S_EST;
                S_EST:
                    state_reg <= S_CMP;
                S_CMP:
                    state_reg <= (est_reg > budget_reg) ? S_LIM_GO : S_EMIT_RD;
                S_LIM_GO:
                    state_reg <= S_LIM_WAIT;
                S_LIM_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD:
                    state_reg <= S_EMIT_LD;
                S_EMIT_LD:
                begin
                    if (load)
                    begin
                        if (at_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // show arithmetic and output register
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sum_reg   <= '0;
            scale_reg <= bright_scale(bright_reg);
        end
        else if (pend_reg)
        begin
            sum_reg <= sum_reg + SW'(pix.r) + SW'(pix.g) + SW'(pix.b);
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PW'(sum_reg) * PW'(scale_reg);
        end
        if (state_reg == S_EST)
        begin
            est_reg <= QUO_W'(est_prod >> EST_SHIFT);
        end
        if (state_reg == S_LIM_WAIT && div_rsp.done)
        begin
            scale_reg <= div_rsp.quotient[7:0];
        end
        if (load)
        begin
            led_index_reg <= 6'(cnt_reg);
            out_red_reg   <= scale_chan(pix.r, scale_reg);
            out_green_reg <= scale_chan(pix.g, scale_reg);
            out_blue_reg  <= scale_chan(pix.b, scale_reg);
            last_reg      <= at_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign led_index = led_index_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign last      = last_reg;

    // the final pixel of a run carries the top strip position
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> led_index == 6'(PIXELS - 1))
        else $error("last flag on wrong pixel");

    // the divider is never restarted while busy
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    // a limited scale never exceeds the unlimited one
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LIM_WAIT && div_rsp.done |-> div_rsp.quotient <= 16'(scale_reg))
        else $error("limited scale above brightness scale");

    // a show or clear item starts the summing pass on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (func == FN_SHOW || func == FN_CLEAR) |=> state_reg == S_SUM)
        else $error("show item did not start summing");

    // no new item while the pixels of a run are being emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT_LD |-> !in_ready)
        else $error("input taken during output run");

endmodule

/* tb/sv/tb_led_matrix_power_limiter.sv */
// self-checking testbench for the led matrix power limiter: frame store, mapping and show output
module tb_led_matrix_power_limiter;
    timeunit 1ns;
    timeprecision 1ps;

    import lmpl_pkg::*;

    localparam int SIDE          = 8;
    localparam int PIXELS        = SIDE * SIDE;
    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_REPORTS   = 30;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 57;
    localparam int HOLD_CYCLES   = 600;

    typedef struct packed {
        logic [5:0] led_index;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
    } pixel_t;

    class panel_scoreboard;
        rgb_t        frame [PIXELS];
        logic [6:0]  brightness;
        logic [15:0] budget;
        logic        serpentine;
        logic [1:0]  rotation;
        pixel_t      pending_pixels [$];
        int unsigned error_count;
        int unsigned pixels_checked;
        int unsigned frames_shown;

        function new();
            foreach (frame[i])
                frame[i] = '0;
            brightness     = BRIGHT_RESET;
            budget         = BUDGET_RESET;
            serpentine     = 1'b0;
            rotation       = 2'd0;
            error_count    = 0;
            pixels_checked = 0;
            frames_shown   = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BRIGHTNESS: brightness = (data[6:0] > BRIGHT_MAX) ? BRIGHT_MAX : data[6:0];
                CFG_BUDGET:     budget     = data;
                CFG_SERPENTINE: serpentine = data[0];
                CFG_ROTATION:   rotation   = data[1:0];
                default: ;
            endcase
        endfunction

        // logical x,y to strip position: rotate content, then serpentine rows
        function int strip_position(int cx, int cy);
            int px;
            int py;
            case (rotation)
                2'd1:    begin px = SIDE - 1 - cy; py = cx; end
                2'd2:    begin px = SIDE - 1 - cx; py = SIDE - 1 - cy; end
                2'd3:    begin px = cy; py = SIDE - 1 - cx; end
                default: begin px = cx; py = cy; end
            endcase
            if (serpentine && py[0])
                px = SIDE - 1 - px;
            return py * SIDE + px;
        endfunction

        function void queue_frame_pixels();
            longint unsigned total;
            longint unsigned scale;
            longint unsigned estimate;
            pixel_t          p;
            int              i;
            total = 0;
            foreach (frame[k])
                total += longint'(frame[k].r) + frame[k].g + frame[k].b;
            scale    = longint'(brightness) * CHAN_MAX / BRIGHT_MAX;
            estimate = total * scale * MA_PER_CHANNEL / (CHAN_MAX * CHAN_MAX);
            // over budget: cut the scale in proportion
            if (estimate > budget && estimate > 0)
                scale = scale * budget / estimate;
            for (i = 0; i < PIXELS; i++)
            begin
                p.led_index = 6'(i);
                p.r         = 8'(longint'(frame[i].r) * scale / CHAN_MAX);
                p.g         = 8'(longint'(frame[i].g) * scale / CHAN_MAX);
                p.b         = 8'(longint'(frame[i].b) * scale / CHAN_MAX);
                p.last      = (i == PIXELS - 1);
                pending_pixels.push_back(p);
            end
            frames_shown++;
        endfunction

        function void take_command(logic [1:0] f, logic [3:0] cx, logic [3:0] cy,
                                   logic [7:0] r, logic [7:0] g, logic [7:0] b);
            case (f)
                FN_SET:
                begin
                    if (cx < SIDE && cy < SIDE)
                        frame[strip_position(cx, cy)] = {r, g, b};
                end
                FN_FILL:
                begin
                    foreach (frame[i])
                        frame[i] = {r, g, b};
                end
                FN_SHOW:
                    queue_frame_pixels();
                default:
                begin
                    foreach (frame[i])
                        frame[i] = '0;
                    queue_frame_pixels();
                end
            endcase
        endfunction

        task report_mismatch(string what);
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_pixel(logic [5:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                         logic lst);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                report_mismatch($sformatf("pixel %0d arrived with nothing pending", idx));
                return;
            end
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (idx !== want.led_index)
                report_mismatch($sformatf("led_index %0d, wanted %0d", idx, want.led_index));
            if (r !== want.r)
                report_mismatch($sformatf("pixel %0d red %0d, wanted %0d", want.led_index, r,
                                          want.r));
            if (g !== want.g)
                report_mismatch($sformatf("pixel %0d green %0d, wanted %0d", want.led_index, g,
                                          want.g));
            if (b !== want.b)
                report_mismatch($sformatf("pixel %0d blue %0d, wanted %0d", want.led_index, b,
                                          want.b));
            if (lst !== want.last)
                report_mismatch($sformatf("pixel %0d last %0b, wanted %0b", want.led_index, lst,
                                          want.last));
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [1:0]            func      = FN_SET;
    logic [3:0]            x         = '0;
    logic [3:0]            y         = '0;
    logic [7:0]            red       = '0;
    logic [7:0]            green     = '0;
    logic [7:0]            blue      = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [5:0]            led_index;
    logic [7:0]            out_red;
    logic [7:0]            out_green;
    logic [7:0]            out_blue;
    logic                  last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    panel_scoreboard sb;
    int unsigned     cycle_count  = 0;
    int unsigned     items_sent   = 0;
    int unsigned     cfg_writes   = 0;
    int unsigned     settings_set = 0;
    int              tx_idle_pct  = 0;
    int              rx_stall_pct = 0;
    int              rx_hold_left = 0;

    led_matrix_power_limiter #(
        .SIDE(SIDE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .x        (x),
        .y        (y),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .led_index(led_index),
        .out_red  (out_red),
        .out_green(out_green),
        .out_blue (out_blue),
        .last     (last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d pixels still pending", cycle_count,
                 sb.pending_pixels.size());
        $display("tb_led_matrix_power_limiter: done, errors");
        $finish;
    end

    // output side: check each accepted pixel, then pick the next ready level
    initial
    begin : pixel_sink
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_pixel(led_index, out_red, out_green, out_blue, last);
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    function automatic logic [7:0] random_level();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return 8'd0;
        if (pick < 30)
            return 8'd255;
        return 8'($urandom);
    endfunction

    task automatic send_item(logic [1:0] f, logic [3:0] cx, logic [3:0] cy,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        x        <= cx;
        y        <= cy;
        red      <= r;
        green    <= g;
        blue     <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.take_command(f, cx, cy, r, g, b);
        items_sent++;
    endtask

    task automatic send_random_item();
        int         pick;
        logic [1:0] f;
        logic [3:0] cx;
        logic [3:0] cy;
        pick = $urandom_range(0, 99);
        if (pick < 62)
            f = FN_SET;
        else if (pick < 74)
            f = FN_FILL;
        else if (pick < 92)
            f = FN_SHOW;
        else
            f = FN_CLEAR;
        // mostly on the panel, now and then anywhere in the 4-bit range
        cx = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, SIDE - 1)) : 4'($urandom);
        cy = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, SIDE - 1)) : 4'($urandom);
        send_item(f, cx, cy, random_level(), random_level(), random_level());
    endtask

    // stop offering items until every pending pixel is back, then let the block settle
    task automatic wait_for_drain(int settle);
        in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_register(idx, data);
        cfg_writes++;
    endtask

    task automatic apply_settings(logic [15:0] bright_data, logic [15:0] budget_data,
                                  logic [15:0] serp_data, logic [15:0] rot_data);
        write_register(CFG_BRIGHTNESS, bright_data);
        write_register(CFG_BUDGET, budget_data);
        write_register(CFG_SERPENTINE, serp_data);
        write_register(CFG_ROTATION, rot_data);
        // an index with no register behind it
        write_register(4'($urandom_range(4, 15)), 16'($urandom));
        cfg_valid <= 1'b0;
        settings_set++;
    endtask

    task automatic random_settings();
        logic [15:0] bright_data;
        logic [15:0] budget_data;
        case ($urandom_range(0, 3))
            0:       bright_data = 16'($urandom);
            default: bright_data = 16'($urandom_range(0, 100));
        endcase
        case ($urandom_range(0, 3))
            0:       budget_data = 16'($urandom);
            1:       budget_data = 16'($urandom_range(0, 50));
            default: budget_data = 16'($urandom_range(100, 4000));
        endcase
        apply_settings(bright_data, budget_data, 16'($urandom), 16'($urandom));
    endtask

    initial
    begin : stimulus
        int phase;
        int n;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: black frame, corners, off-panel writes
        send_item(FN_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0);
        send_item(FN_SET, 4'd0, 4'd0, 8'd255, 8'd255, 8'd255);
        send_item(FN_SET, 4'd7, 4'd0, 8'd255, 8'd0, 8'd0);
        send_item(FN_SET, 4'd0, 4'd7, 8'd0, 8'd255, 8'd0);
        send_item(FN_SET, 4'd7, 4'd7, 8'd0, 8'd0, 8'd255);
        send_item(FN_SET, 4'd8, 4'd3, 8'd255, 8'd255, 8'd255);
        send_item(FN_SET, 4'd3, 4'd15, 8'd255, 8'd255, 8'd255);
        send_item(FN_SET, 4'd15, 4'd15, 8'd255, 8'd255, 8'd255);
        send_item(FN_SHOW, 4'd15, 4'd15, 8'd255, 8'd255, 8'd255);
        wait_for_drain(SETTLE_CYCLES);

        // brightness write above range saturates; white frame goes over budget
        apply_settings(16'hffff, 16'd2600, 16'd1, 16'd1);
        send_item(FN_SET, 4'd1, 4'd0, 8'd10, 8'd20, 8'd30);
        send_item(FN_SET, 4'd0, 4'd1, 8'd40, 8'd50, 8'd60);
        send_item(FN_SET, 4'd6, 4'd2, 8'd70, 8'd80, 8'd90);
        send_item(FN_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0);
        send_item(FN_FILL, 4'd0, 4'd0, 8'd255, 8'd255, 8'd255);
        send_item(FN_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0);
        wait_for_drain(SETTLE_CYCLES);

        apply_settings(16'd100, 16'hffff, 16'd1, 16'd2);
        send_item(FN_SET, 4'd2, 4'd5, 8'd200, 8'd1, 8'd128);
        send_item(FN_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0);
        wait_for_drain(SETTLE_CYCLES);

        // zero budget blanks a lit frame; clear after a fill
        apply_settings(16'd80, 16'd0, 16'd0, 16'd3);
        send_item(FN_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0);
        send_item(FN_FILL, 4'd0, 4'd0, 8'd128, 8'd64, 8'd32);
        send_item(FN_CLEAR, 4'd9, 4'd9, 8'd255, 8'd255, 8'd255);
        wait_for_drain(SETTLE_CYCLES);

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       apply_settings(16'd100, 16'd1000, 16'd0, 16'd0);
                1:       apply_settings(16'd0, 16'hffff, 16'd1, 16'd3);
                default: random_settings();
            endcase
            case (phase % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 47; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 47; end
                default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
            endcase
            // long receiver hold-off while items keep coming, so the block backs up
            if (phase == 2)
            begin
                rx_hold_left = HOLD_CYCLES;
                send_item(FN_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0);
                send_item(FN_SET, 4'd3, 4'd4, 8'd255, 8'd0, 8'd255);
                send_item(FN_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0);
            end
            for (n = 0; n < PHASE_ITEMS; n++)
                send_random_item();
            wait_for_drain(SETTLE_CYCLES);
        end

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        wait_for_drain(TAIL_CYCLES);

        $display("covered %0d commands, %0d frames shown, %0d pixels compared",
                 items_sent, sb.frames_shown, sb.pixels_checked);
        $display("%0d register writes over %0d settings, %0d mismatches",
                 cfg_writes, settings_set, sb.error_count);
        if (sb.error_count == 0 && sb.pending_pixels.size() == 0)
            $display("tb_led_matrix_power_limiter: done, clean");
        else
            $display("tb_led_matrix_power_limiter: done, errors");
        $finish;
    end

endmodule
